/* hdl/lru_block_cache_macros.svh */
// Assertion macros shared by the cache RTL.
`ifndef LRU_BLOCK_CACHE_MACROS_SVH
`define LRU_BLOCK_CACHE_MACROS_SVH

// The condition must never be seen outside reset.
`define LBC_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

// The antecedent in a cycle implies the consequent in that cycle.
`define LBC_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* hdl/lbc_pkg.sv */
// Types and constants of the block cache.
package lbc_pkg;

   localparam int ENT_IDX_W = 12;
   localparam int ENT_CNT_W = 13;

   localparam logic [1:0] FN_STAGE  = 2'd0;
   localparam logic [1:0] FN_LOOKUP = 2'd1;
   localparam logic [1:0] FN_UPDATE = 2'd2;
   localparam logic [1:0] FN_INSERT = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_DUP  = 2'd2;
   localparam logic [1:0] ST_FAIL = 2'd3;

   localparam logic [2:0] CSR_ENABLE  = 3'd0;
   localparam logic [2:0] CSR_ENTRIES = 3'd4;

   // Search word that walks along the entry cells.
   typedef struct packed {
      logic                 active;
      logic                 found;
      logic [ENT_IDX_W-1:0] found_idx;
      logic                 victim;
      logic [ENT_IDX_W-1:0] victim_idx;
      logic [31:0]          lowest;
   } scan_type;

   // Entry write broadcast to all cells.
   typedef struct packed {
      logic                 clear;
      logic                 en;
      logic                 set_tags;
      logic [ENT_IDX_W-1:0] idx;
      logic [3:0]           disk;
      logic [7:0]           blk;
      logic [31:0]          stamp;
   } wr_type;

endpackage

/* hdl/lbc_cell.sv */
// One cache entry: tags, stamp and one stage of the search chain.
module lbc_cell #(
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lbc_pkg::scan_type             scan_in,
   output lbc_pkg::scan_type             scan_out,
   input  lbc_pkg::wr_type               wr,
   input  logic [lbc_pkg::ENT_CNT_W-1:0] live_n,
   input  logic [3:0]                    key_disk,
   input  logic [7:0]                    key_blk
);

   logic              valid_ff;
   logic [3:0]        disk_ff;
   logic [7:0]        blk_ff;
   logic [31:0]       stamp_ff;
   lbc_pkg::scan_type scan_ff;
   lbc_pkg::scan_type scan_in_w;

   always_comb begin
      scan_in_w = scan_in;
      if (scan_in.active && (lbc_pkg::ENT_CNT_W'(INDEX) < live_n)) begin
         if (valid_ff && disk_ff == key_disk && blk_ff == key_blk && !scan_in.found) begin
            scan_in_w.found     = 1'b1;
            scan_in_w.found_idx = lbc_pkg::ENT_IDX_W'(INDEX);
         end
         if (!valid_ff || stamp_ff < scan_in.lowest) begin
            scan_in_w.victim     = 1'b1;
            scan_in_w.victim_idx = lbc_pkg::ENT_IDX_W'(INDEX);
            scan_in_w.lowest     = stamp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff  <= '0;
         valid_ff <= 1'b0;
         disk_ff  <= '0;
         blk_ff   <= '0;
         stamp_ff <= '0;
      end else begin
         scan_ff <= scan_in_w;
         if (wr.clear) begin
            valid_ff <= 1'b0;
            disk_ff  <= '0;
            blk_ff   <= '0;
            stamp_ff <= '0;
         end else if (wr.en && wr.idx == lbc_pkg::ENT_IDX_W'(INDEX)) begin
            stamp_ff <= wr.stamp;
            if (wr.set_tags) begin
               valid_ff <= 1'b1;
               disk_ff  <= wr.disk;
               blk_ff   <= wr.blk;
            end
         end
      end
   end

   assign scan_out = scan_ff;

endmodule

/* hdl/lru_block_cache.sv */
// When enabled, a lookup, update or insert walks the registered cell chain; a stage goes straight to the response.
// A successful update or insert then copies the staged block into the store, one store write per word.
// A lookup hit streams BLOCK_WORDS words, each by a store read, then output, and waits while the output is held.
// One operation at a time; a new word is accepted while the last result still waits.
// Synchronous reset clears entries, staging buffer, counters, clock and enable, and sets the entry count to 2.
module lru_block_cache #(
   parameter int MAX_ENTRIES = 64,
   parameter int BLOCK_WORDS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,  // func
   input  logic [87:0]  req_tdata,  // disk, block_number, word_index, data_in, zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,  // status
   output logic [135:0] rsp_tdata,  // data_out, out_word_index, query_count, hit_count, fill
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   `include "lru_block_cache_macros.svh"

   localparam int WI_W      = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
   localparam int MEM_DEPTH = MAX_ENTRIES * BLOCK_WORDS;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int CW        = lbc_pkg::ENT_CNT_W;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_SCAN = 6'b000010,
      S_COPY = 6'b000100,
      S_RADR = 6'b001000,
      S_RDAT = 6'b010000,
      S_RESP = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic             en_ff;
   logic [6:0]       eiu_ff;
   logic [1:0]       func_ff;
   logic [3:0]       disk_ff;
   logic [7:0]       blk_ff;
   logic [1:0]       status_ff, status_in;
   logic [WI_W-1:0]  word_ff, word_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [31:0]      clk_ff, clk_in, queries_ff, queries_in, hits_ff, hits_in;
   logic [63:0]      stage_ff [BLOCK_WORDS];
   logic [BLOCK_WORDS-1:0] stage_vld_ff;
   logic [63:0]      store_mem [MEM_DEPTH];
   logic [63:0]      rd_ff;
   logic [63:0]      stage_rd;
   logic [ADDR_W-1:0] mem_addr;
   logic             mem_we;

   logic             rsp_valid_ff, rsp_last_ff;
   logic [1:0]       rsp_status_ff;
   logic [63:0]      rsp_data_ff;
   logic [4:0]       rsp_widx_ff;
   logic [31:0]      rsp_q_ff, rsp_h_ff;
   logic             out_load, out_last;
   logic [63:0]      out_data;
   logic             out_free, req_acc, cfg_we, scan_start;
   logic             scan_go_ff;
   logic [CW-1:0]    eiu_w, live_n;
   logic [31:0]      stamp_next;

   lbc_pkg::wr_type   wr;
   lbc_pkg::scan_type chain [MAX_ENTRIES+1];

   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite;
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (csr_paddr)
         lbc_pkg::CSR_ENABLE:  csr_prdata = {31'd0, en_ff};
         lbc_pkg::CSR_ENTRIES: csr_prdata = {25'd0, eiu_ff};
         default:              csr_prdata = '0;
      endcase
   end

   assign eiu_w  = CW'(eiu_ff);
   assign live_n = (eiu_w < CW'(2)) ? CW'(2) :
                   ((eiu_w > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : eiu_w);

   // The search word enters cell zero in the cycle after the accept, once the key is registered,
   // with the current clock as minimum.
   always_comb begin
      chain[0]        = '0;
      chain[0].active = scan_go_ff;
      chain[0].lowest = clk_ff;
   end

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      lbc_cell #(.INDEX(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .scan_in  (chain[g]),
         .scan_out (chain[g+1]),
         .wr       (wr),
         .live_n   (live_n),
         .key_disk (disk_ff),
         .key_blk  (blk_ff)
      );
   end

   assign stage_rd   = stage_vld_ff[word_ff] ? stage_ff[word_ff] : 64'd0;
   assign mem_addr   = base_ff + ADDR_W'(word_ff);
   assign mem_we     = (state_ff == S_COPY);
   assign stamp_next = (clk_ff != '1) ? clk_ff + 32'd1 : clk_ff;

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      word_in    = word_ff;
      base_in    = base_ff;
      clk_in     = clk_ff;
      queries_in = queries_ff;
      hits_in    = hits_ff;
      scan_start = 1'b0;
      out_load   = 1'b0;
      out_last   = 1'b1;
      out_data   = '0;
      wr         = '0;
      wr.clear   = cfg_we && csr_paddr == lbc_pkg::CSR_ENABLE && csr_pwdata[0] && !en_ff;
      wr.disk    = disk_ff;
      wr.blk     = blk_ff;
      wr.stamp   = clk_ff;
      case (state_ff)
         S_IDLE: begin
            word_in = '0;
            if (req_acc) begin
               status_in = lbc_pkg::ST_OK;
               if (req_tuser == lbc_pkg::FN_STAGE) begin
                  state_in = S_RESP;
               end else begin
                  if (req_tuser == lbc_pkg::FN_LOOKUP) queries_in = queries_ff + 32'd1;
                  if (!en_ff) begin
                     status_in = lbc_pkg::ST_FAIL;
                     state_in  = S_RESP;
                  end else begin
                     scan_start = 1'b1;
                     state_in   = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            if (chain[MAX_ENTRIES].active) begin
               state_in = S_RESP;
               base_in  = ADDR_W'(chain[MAX_ENTRIES].found_idx) * ADDR_W'(BLOCK_WORDS);
               wr.idx   = chain[MAX_ENTRIES].found_idx;
               case (func_ff)
                  lbc_pkg::FN_LOOKUP: begin
                     if (chain[MAX_ENTRIES].found) begin
                        hits_in  = hits_ff + 32'd1;
                        wr.en    = 1'b1;
                        clk_in   = stamp_next;
                        state_in = S_RADR;
                     end else begin
                        status_in = lbc_pkg::ST_MISS;
                     end
                  end
                  lbc_pkg::FN_UPDATE: begin
                     if (chain[MAX_ENTRIES].found) begin
                        wr.en    = 1'b1;
                        clk_in   = stamp_next;
                        state_in = S_COPY;
                     end else begin
                        status_in = lbc_pkg::ST_MISS;
                     end
                  end
                  default: begin
                     if (chain[MAX_ENTRIES].found) begin
                        status_in = lbc_pkg::ST_DUP;
                     end else if (!chain[MAX_ENTRIES].victim) begin
                        status_in = lbc_pkg::ST_FAIL;
                     end else begin
                        wr.en       = 1'b1;
                        wr.set_tags = 1'b1;
                        wr.idx      = chain[MAX_ENTRIES].victim_idx;
                        base_in     = ADDR_W'(chain[MAX_ENTRIES].victim_idx) *
                                      ADDR_W'(BLOCK_WORDS);
                        clk_in      = stamp_next;
                        queries_in  = queries_ff + 32'd1;
                        state_in    = S_COPY;
                     end
                  end
               endcase
            end
         end
         S_COPY: begin
            if (word_ff == WI_W'(BLOCK_WORDS - 1)) begin
               state_in = S_RESP;
            end else begin
               word_in = word_ff + WI_W'(1);
            end
         end
         S_RADR: begin
            state_in = S_RDAT;
         end
         S_RDAT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_data = rd_ff;
               out_last = (word_ff == WI_W'(BLOCK_WORDS - 1));
               if (out_last) begin
                  state_in = S_IDLE;
               end else begin
                  word_in  = word_ff + WI_W'(1);
                  state_in = S_RADR;
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_addr] <= stage_rd;
      rd_ff <= store_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_tuser == lbc_pkg::FN_STAGE &&
          7'(req_tdata[16:12]) < 7'(BLOCK_WORDS)) begin
         stage_ff[WI_W'(req_tdata[16:12])] <= req_tdata[80:17];
      end
      if (req_acc) begin
         func_ff <= req_tuser;
         disk_ff <= req_tdata[3:0];
         blk_ff  <= req_tdata[11:4];
      end
      status_ff <= status_in;
      word_ff   <= word_in;
      base_ff   <= base_in;
      if (out_load) begin
         rsp_status_ff <= (state_ff == S_RDAT) ? lbc_pkg::ST_OK : status_ff;
         rsp_data_ff   <= out_data;
         rsp_widx_ff   <= (state_ff == S_RDAT) ? 5'(word_ff) : 5'd0;
         rsp_last_ff   <= out_last;
         rsp_q_ff      <= queries_ff;
         rsp_h_ff      <= hits_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         en_ff        <= 1'b0;
         eiu_ff       <= 7'd2;
         clk_ff       <= '0;
         queries_ff   <= '0;
         hits_ff      <= '0;
         stage_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
         scan_go_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clk_ff     <= clk_in;
         queries_ff <= queries_in;
         hits_ff    <= hits_in;
         scan_go_ff <= scan_start;
         if (cfg_we && csr_paddr == lbc_pkg::CSR_ENABLE)  en_ff  <= csr_pwdata[0];
         if (cfg_we && csr_paddr == lbc_pkg::CSR_ENTRIES) eiu_ff <= csr_pwdata[6:0];
         if (req_acc && req_tuser == lbc_pkg::FN_STAGE &&
             7'(req_tdata[16:12]) < 7'(BLOCK_WORDS)) begin
            stage_vld_ff[WI_W'(req_tdata[16:12])] <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'd0, rsp_h_ff, rsp_q_ff, rsp_widx_ff, rsp_data_ff};

   `LBC_NEVER(a_clock_monotonic, clk_ff < $past(clk_ff), "access clock went backward")
   `LBC_IMPLIES(a_hit_from_scan, hits_ff != $past(hits_ff), $past(state_ff) == S_SCAN,
                "hit counted outside a search")
   `LBC_NEVER(a_data_only_on_hit,
              rsp_valid_ff && rsp_status_ff != lbc_pkg::ST_OK && rsp_data_ff != 64'd0,
              "data word on a failed operation")

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the LRU block cache: random and directed traffic against a predictor.
module testbench;

   localparam int NENT  = 64;
   localparam int NWORD = 32;

   typedef struct {
      logic [1:0]  status;
      logic [63:0] data;
      logic [4:0]  widx;
      logic        last;
      logic [31:0] queries;
      logic [31:0] hits;
   } cache_word_type;

   class cache_scoreboard;
      logic        enable;
      logic [6:0]  entries_reg;
      logic        valid [NENT];
      logic [3:0]  disk_tag [NENT];
      logic [7:0]  block_tag [NENT];
      logic [31:0] stamp [NENT];
      logic [63:0] store [NENT*NWORD];
      logic [63:0] staging [NWORD];
      logic [31:0] clk_count, queries, hits;
      cache_word_type pending_q[$];
      int errors, results, hit_ops;

      function new();
         enable = 0;
         entries_reg = 2;
         clear_entries();
         foreach (staging[i]) staging[i] = '0;
         clk_count = 0;
         queries = 0;
         hits = 0;
         errors = 0;
         results = 0;
         hit_ops = 0;
      endfunction

      function void clear_entries();
         for (int i = 0; i < NENT; i++) begin
            valid[i] = 0;
            disk_tag[i] = '0;
            block_tag[i] = '0;
            stamp[i] = '0;
         end
      endfunction

      function int live();
         int n;
         n = entries_reg;
         if (n < 2) n = 2;
         if (n > NENT) n = NENT;
         return n;
      endfunction

      function int find(logic [3:0] d, logic [7:0] b);
         for (int i = 0; i < live(); i++)
            if (valid[i] && disk_tag[i] == d && block_tag[i] == b) return i;
         return -1;
      endfunction

      function logic [31:0] next_stamp();
         logic [31:0] s;
         s = clk_count;
         if (clk_count != '1) clk_count++;
         return s;
      endfunction

      function void push(logic [1:0] st, logic [63:0] data, logic [4:0] w, logic last);
         cache_word_type r;
         r.status = st;
         r.data = data;
         r.widx = w;
         r.last = last;
         r.queries = queries;
         r.hits = hits;
         pending_q.push_back(r);
      endfunction

      function void write_reg(logic [2:0] addr, logic [31:0] value);
         if (addr == lbc_pkg::CSR_ENABLE) begin
            if (value[0] && !enable) clear_entries();
            enable = value[0];
         end else if (addr == lbc_pkg::CSR_ENTRIES) begin
            entries_reg = value[6:0];
         end
      endfunction

      function void note(logic [1:0] fn, logic [3:0] d, logic [7:0] b, logic [4:0] w,
                         logic [63:0] data);
         int e;
         logic [31:0] lowest;
         if (fn == lbc_pkg::FN_STAGE) begin
            staging[w] = data;
            push(lbc_pkg::ST_OK, '0, '0, 1);
         end else if (fn == lbc_pkg::FN_LOOKUP) begin
            queries++;
            if (!enable) push(lbc_pkg::ST_FAIL, '0, '0, 1);
            else begin
               e = find(d, b);
               if (e < 0) push(lbc_pkg::ST_MISS, '0, '0, 1);
               else begin
                  hits++;
                  hit_ops++;
                  stamp[e] = next_stamp();
                  for (int i = 0; i < NWORD; i++)
                     push(lbc_pkg::ST_OK, store[e*NWORD+i], i[4:0], i == NWORD-1);
               end
            end
         end else if (fn == lbc_pkg::FN_UPDATE) begin
            if (!enable) push(lbc_pkg::ST_FAIL, '0, '0, 1);
            else begin
               e = find(d, b);
               if (e < 0) push(lbc_pkg::ST_MISS, '0, '0, 1);
               else begin
                  for (int i = 0; i < NWORD; i++) store[e*NWORD+i] = staging[i];
                  stamp[e] = next_stamp();
                  push(lbc_pkg::ST_OK, '0, '0, 1);
               end
            end
         end else begin
            if (!enable) push(lbc_pkg::ST_FAIL, '0, '0, 1);
            else if (find(d, b) >= 0) push(lbc_pkg::ST_DUP, '0, '0, 1);
            else begin
               // Later invalid entries or strictly older stamps take over the choice.
               e = -1;
               lowest = clk_count;
               for (int i = 0; i < live(); i++)
                  if (!valid[i] || stamp[i] < lowest) begin
                     e = i;
                     lowest = stamp[i];
                  end
               if (e < 0) push(lbc_pkg::ST_FAIL, '0, '0, 1);
               else begin
                  valid[e] = 1;
                  disk_tag[e] = d;
                  block_tag[e] = b;
                  for (int i = 0; i < NWORD; i++) store[e*NWORD+i] = staging[i];
                  stamp[e] = next_stamp();
                  queries++;
                  push(lbc_pkg::ST_OK, '0, '0, 1);
               end
            end
         end
      endfunction

      function void check(cache_word_type got);
         cache_word_type want;
         results++;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected word: status %0d data %h", got.status, got.data);
            return;
         end
         want = pending_q.pop_front();
         if (got.status !== want.status || got.data !== want.data || got.widx !== want.widx ||
             got.last !== want.last || got.queries !== want.queries || got.hits !== want.hits) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp st %0d d %h w %0d l %0d q %0d h %0d, %s",
                        want.status, want.data, want.widx, want.last, want.queries, want.hits,
                        $sformatf("got st %0d d %h w %0d l %0d q %0d h %0d",
                                  got.status, got.data, got.widx, got.last, got.queries,
                                  got.hits));
         end
      endfunction
   endclass

   logic         clock, reset;
   logic         req_tvalid, req_tready;
   logic [1:0]   req_tuser;
   logic [87:0]  req_tdata;
   logic         rsp_tvalid, rsp_tready, rsp_tlast;
   logic [1:0]   rsp_tuser;
   logic [135:0] rsp_tdata;
   logic         csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata, csr_prdata;

   cache_scoreboard sb;
   int send_idle, recv_idle, items;
   logic [3:0] key_disk [6];
   logic [7:0] key_blk [6];

   lru_block_cache dut (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle);

   always @(posedge clock) begin
      cache_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.data = rsp_tdata[63:0];
         got.widx = rsp_tdata[68:64];
         got.queries = rsp_tdata[100:69];
         got.hits = rsp_tdata[132:101];
         got.last = rsp_tlast;
         sb.check(got);
      end
   end

   // Called at a falling edge; returns at a falling edge after the word is taken.
   task automatic send(logic [1:0] fn, logic [3:0] d, logic [7:0] b, logic [4:0] w,
                       logic [63:0] data);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= fn;
      req_tdata <= {7'd0, data, w, b, d};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note(fn, d, b, w, data);
      items++;
      @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      req_tvalid <= 1'b0;
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(addr, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every expected word has come out, then lets the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic random_ops(int count);
      int k, sel;
      logic [3:0] d;
      logic [7:0] b;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(5);
         d = key_disk[k];
         b = key_blk[k];
         if ($urandom_range(9) < 3) begin
            d = 4'($urandom);
            b = 8'($urandom);
         end
         sel = $urandom_range(99);
         if (sel < 30) send(lbc_pkg::FN_STAGE, d, b, 5'($urandom), {$urandom, $urandom});
         else if (sel < 60) send(lbc_pkg::FN_LOOKUP, d, b, 5'($urandom), {$urandom, $urandom});
         else if (sel < 75) send(lbc_pkg::FN_UPDATE, d, b, 5'($urandom), {$urandom, $urandom});
         else send(lbc_pkg::FN_INSERT, d, b, 5'($urandom), {$urandom, $urandom});
      end
   endtask

   initial begin
      sb = new();
      items = 0;
      send_idle = 20;
      recv_idle = 76;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      for (int i = 0; i < 6; i++) begin
         key_disk[i] = 4'($urandom);
         key_blk[i] = 8'($urandom);
      end
      key_disk[0] = 4'hf;
      key_blk[0] = 8'hff;
      key_disk[1] = 4'h0;
      key_blk[1] = 8'h00;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Disabled cache: every lookup, update and insert fails.
      send(lbc_pkg::FN_LOOKUP, 4'hf, 8'hff, 5'd0, '0);
      send(lbc_pkg::FN_UPDATE, 4'hf, 8'hff, 5'd0, '0);
      send(lbc_pkg::FN_INSERT, 4'hf, 8'hff, 5'd0, '0);
      drain();
      csr_write(lbc_pkg::CSR_ENABLE, 32'd1);
      csr_write(lbc_pkg::CSR_ENTRIES, 32'd2);
      send(lbc_pkg::FN_STAGE, 4'h0, 8'h00, 5'd0, '1);
      send(lbc_pkg::FN_STAGE, 4'hf, 8'hff, 5'd31, '0);
      send(lbc_pkg::FN_STAGE, 4'h5, 8'h5a, 5'd7, {$urandom, $urandom});
      send(lbc_pkg::FN_INSERT, 4'hf, 8'hff, 5'd31, '0);
      send(lbc_pkg::FN_INSERT, 4'hf, 8'hff, 5'd0, '1);
      send(lbc_pkg::FN_LOOKUP, 4'hf, 8'hff, 5'd0, '0);
      send(lbc_pkg::FN_LOOKUP, 4'h0, 8'h00, 5'd0, '0);
      send(lbc_pkg::FN_INSERT, 4'h0, 8'h00, 5'd0, '0);
      send(lbc_pkg::FN_STAGE, 4'h0, 8'h00, 5'd0, 64'h0123_4567_89ab_cdef);
      send(lbc_pkg::FN_UPDATE, 4'h0, 8'h00, 5'd0, '0);
      send(lbc_pkg::FN_UPDATE, 4'h3, 8'h33, 5'd0, '0);
      send(lbc_pkg::FN_INSERT, 4'h3, 8'h33, 5'd0, '0);
      send(lbc_pkg::FN_LOOKUP, 4'hf, 8'hff, 5'd0, '0);
      send(lbc_pkg::FN_LOOKUP, 4'h0, 8'h00, 5'd0, '0);
      send(lbc_pkg::FN_LOOKUP, 4'h3, 8'h33, 5'd0, '0);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         send_idle = (ph < 2) ? 20 : (ph < 4) ? 76 : 0;
         recv_idle = (ph < 2) ? 76 : (ph < 4) ? 20 : 0;
         case (ph)
            0: csr_write(lbc_pkg::CSR_ENTRIES, 32'd3);
            1: csr_write(lbc_pkg::CSR_ENTRIES, 32'd127);
            2: begin
               csr_write(lbc_pkg::CSR_ENABLE, 32'd0);
               csr_write(lbc_pkg::CSR_ENTRIES, 32'd0);
            end
            3: csr_write(lbc_pkg::CSR_ENABLE, 32'd1);
            4: begin
               csr_write(lbc_pkg::CSR_ENABLE, 32'd1);
               csr_write(lbc_pkg::CSR_ENTRIES, 32'd64);
            end
            default: csr_write(lbc_pkg::CSR_ENTRIES, 32'd4);
         endcase
         random_ops(22);
         drain();
      end

      sb.errors += sb.pending_q.size();
      $display("ran %0d words in, %0d words out, %0d lookup hits", items, sb.results,
               sb.hit_ops);
      $display("covered disabled, miss, duplicate, update and eviction paths at six settings");
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
